// ===== design/sparse_polynomial_add_defines.svh =====
// Assertion macros shared by the sparse polynomial adder RTL.
// No dependencies; included by spa_datapath, which checks its own logic.
`ifndef SPARSE_POLYNOMIAL_ADD_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADD_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SPA_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/spa_pkg.sv =====
// Shared widths, saturation limits and controller/datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package spa_pkg;

   localparam int EXP_W  = 16;
   localparam int COEF_W = 32;

   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   // Controller to datapath
   typedef struct packed {
      logic load;      // request transfer: store the term
      logic compare;   // one merge step on the fetched heads
      logic finish;    // both lists exhausted: build the final result
      logic clear;     // final result taken: empty both stores
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic start_merge;  // request payload closes list B
      logic more;         // at least one list still has terms
      logic emit;         // this step pushes a result out
   } sts_type;

endpackage

// ===== design/spa_channels.sv =====
// Request and response channel interfaces of the sparse polynomial adder.
// Depends on spa_pkg for field widths.
`timescale 1ns / 1ps

interface spa_req_if
   import spa_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              list_select;
   logic              term_valid;
   logic [EXP_W-1:0]  exponent;
   logic [COEF_W-1:0] coefficient;
   logic              last_term;

   modport source (output valid, list_select, term_valid, exponent, coefficient,
                   last_term, input ready);
   modport sink   (input valid, list_select, term_valid, exponent, coefficient,
                   last_term, output ready);
endinterface

interface spa_rsp_if
   import spa_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [EXP_W-1:0]  out_exponent;
   logic [COEF_W-1:0] out_coefficient;
   logic              out_last;
   logic              sum_empty;
   logic              overflow;

   modport source (output valid, out_exponent, out_coefficient, out_last, sum_empty,
                   overflow, input ready);
   modport sink   (input valid, out_exponent, out_coefficient, out_last, sum_empty,
                   overflow, output ready);
endinterface

// ===== design/spa_datapath.sv =====
// Term stores, merge pointers, saturating adder and result registers.
// Depends on spa_pkg and sparse_polynomial_add_defines.svh; driven by spa_ctrl.
`timescale 1ns / 1ps
`include "sparse_polynomial_add_defines.svh"

module spa_datapath
   import spa_pkg::*;
#(
   parameter int MAX_TERMS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              list_select,
   input  logic              term_valid,
   input  logic [EXP_W-1:0]  exponent,
   input  logic [COEF_W-1:0] coefficient,
   input  logic              last_term,
   output logic [EXP_W-1:0]  out_exponent,
   output logic [COEF_W-1:0] out_coefficient,
   output logic              out_last,
   output logic              sum_empty,
   output logic              overflow
);

   localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TERMS);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   logic [EXP_W-1:0]  first_exponents     [MAX_TERMS];
   logic [COEF_W-1:0] first_coefficients  [MAX_TERMS];
   logic [EXP_W-1:0]  second_exponents    [MAX_TERMS];
   logic [COEF_W-1:0] second_coefficients [MAX_TERMS];

   logic [CNT_W-1:0]  first_count_ff, first_count_in;
   logic [CNT_W-1:0]  second_count_ff, second_count_in;
   logic              dropped_ff, dropped_in;
   logic [CNT_W-1:0]  ptr_a_ff, ptr_a_in;
   logic [CNT_W-1:0]  ptr_b_ff, ptr_b_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [EXP_W-1:0]  pend_exp_ff;
   logic [COEF_W-1:0] pend_coef_ff;

   logic [EXP_W-1:0]  head_exp_a_ff, head_exp_b_ff;
   logic [COEF_W-1:0] head_coef_a_ff, head_coef_b_ff;

   logic [EXP_W-1:0]  out_exp_ff;
   logic [COEF_W-1:0] out_coef_ff;
   logic              out_last_ff, out_empty_ff, out_ovf_ff;

   logic              wr_a, wr_b;
   logic              a_ok, b_ok, take_a, take_b, both, found;
   logic [COEF_W:0]   sum_wide;
   logic [COEF_W-1:0] sum_sat, new_coef;
   logic [EXP_W-1:0]  new_exp;

   // ---------------- loading ----------------
   assign wr_a = cmd.load && term_valid && !list_select && (first_count_ff < CNT_FULL);
   assign wr_b = cmd.load && term_valid &&  list_select && (second_count_ff < CNT_FULL);

   always_ff @(posedge clock) begin
      if (wr_a) begin
         first_exponents[first_count_ff[IDX_W-1:0]]    <= exponent;
         first_coefficients[first_count_ff[IDX_W-1:0]] <= coefficient;
      end
      if (wr_b) begin
         second_exponents[second_count_ff[IDX_W-1:0]]    <= exponent;
         second_coefficients[second_count_ff[IDX_W-1:0]] <= coefficient;
      end
   end

   // Registered read ports: heads of both lists, in the cycle after the pointer moves
   always_ff @(posedge clock) begin
      head_exp_a_ff  <= first_exponents[ptr_a_ff[IDX_W-1:0]];
      head_coef_a_ff <= first_coefficients[ptr_a_ff[IDX_W-1:0]];
      head_exp_b_ff  <= second_exponents[ptr_b_ff[IDX_W-1:0]];
      head_coef_b_ff <= second_coefficients[ptr_b_ff[IDX_W-1:0]];
   end

   // ---------------- merge step ----------------
   assign a_ok = ptr_a_ff < first_count_ff;
   assign b_ok = ptr_b_ff < second_count_ff;

   always_comb begin
      take_a = 1'b0;
      take_b = 1'b0;
      if (a_ok && b_ok) begin
         if (head_exp_a_ff == head_exp_b_ff) begin
            take_a = 1'b1;
            take_b = 1'b1;
         end else if (head_exp_a_ff > head_exp_b_ff) begin
            take_a = 1'b1;
         end else begin
            take_b = 1'b1;
         end
      end else if (a_ok) begin
         take_a = 1'b1;
      end else if (b_ok) begin
         take_b = 1'b1;
      end
   end

   assign both     = take_a && take_b;
   assign sum_wide = {head_coef_a_ff[COEF_W-1], head_coef_a_ff}
                   + {head_coef_b_ff[COEF_W-1], head_coef_b_ff};

   always_comb begin
      if (sum_wide[COEF_W] != sum_wide[COEF_W-1]) begin
         sum_sat = sum_wide[COEF_W] ? COEF_MIN : COEF_MAX;
      end else begin
         sum_sat = sum_wide[COEF_W-1:0];
      end
   end

   assign new_exp  = take_a ? head_exp_a_ff : head_exp_b_ff;
   assign new_coef = both ? sum_sat : (take_a ? head_coef_a_ff : head_coef_b_ff);
   // cancelled pair yields no term; saturation never lands on zero
   assign found    = !(both && (sum_sat == '0));

   assign sts.start_merge = list_select && last_term;
   assign sts.more        = a_ok || b_ok;
   // a term is held back one step so the final one can carry the last mark
   assign sts.emit        = found && pend_valid_ff;

   // ---------------- control registers ----------------
   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      ptr_a_in        = ptr_a_ff;
      ptr_b_in        = ptr_b_ff;
      pend_valid_in   = pend_valid_ff;
      if (cmd.load && term_valid) begin
         if (!list_select) begin
            if (wr_a) begin
               first_count_in = first_count_ff + CNT_ONE;
            end else begin
               dropped_in = 1'b1;
            end
         end else begin
            if (wr_b) begin
               second_count_in = second_count_ff + CNT_ONE;
            end else begin
               dropped_in = 1'b1;
            end
         end
      end
      if (cmd.compare) begin
         if (take_a) begin
            ptr_a_in = ptr_a_ff + CNT_ONE;
         end
         if (take_b) begin
            ptr_b_in = ptr_b_ff + CNT_ONE;
         end
         if (found) begin
            pend_valid_in = 1'b1;
         end
      end
      if (cmd.clear) begin
         first_count_in  = '0;
         second_count_in = '0;
         dropped_in      = 1'b0;
         ptr_a_in        = '0;
         ptr_b_in        = '0;
         pend_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
         ptr_a_ff        <= '0;
         ptr_b_ff        <= '0;
         pend_valid_ff   <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
         ptr_a_ff        <= ptr_a_in;
         ptr_b_ff        <= ptr_b_in;
         pend_valid_ff   <= pend_valid_in;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (cmd.compare && found) begin
         pend_exp_ff  <= new_exp;
         pend_coef_ff <= new_coef;
      end
      if (cmd.compare && sts.emit) begin
         out_exp_ff   <= pend_exp_ff;
         out_coef_ff  <= pend_coef_ff;
         out_last_ff  <= 1'b0;
         out_empty_ff <= 1'b0;
         out_ovf_ff   <= dropped_ff;
      end else if (cmd.finish) begin
         out_exp_ff   <= pend_valid_ff ? pend_exp_ff : '0;
         out_coef_ff  <= pend_valid_ff ? pend_coef_ff : '0;
         out_last_ff  <= 1'b1;
         out_empty_ff <= !pend_valid_ff;
         out_ovf_ff   <= dropped_ff;
      end
   end

   assign out_exponent    = out_exp_ff;
   assign out_coefficient = out_coef_ff;
   assign out_last        = out_last_ff;
   assign sum_empty       = out_empty_ff;
   assign overflow        = out_ovf_ff;

   `SPA_ASSERT_NOW(a_ptr_in_range, 1'b1, (ptr_a_ff <= first_count_ff) && (ptr_b_ff <= second_count_ff), "merge pointer passed its count")
   `SPA_ASSERT_NOW(a_count_in_range, 1'b1, (first_count_ff <= CNT_FULL) && (second_count_ff <= CNT_FULL), "store count beyond capacity")
   `SPA_ASSERT_NEXT(a_finish_marks_last, cmd.finish, out_last_ff && (out_empty_ff == !pend_valid_ff), "final result not marked")

endmodule

// ===== design/spa_ctrl.sv =====
// Controller state machine: load phase, merge step sequencing, result handshake.
// Depends on spa_pkg; commands spa_datapath.
`timescale 1ns / 1ps

module spa_ctrl
   import spa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_READ      = 5'b00010,
      ST_COMPARE   = 5'b00100,
      ST_EMIT      = 5'b01000,
      ST_EMIT_LAST = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.start_merge) begin
                  state_in = ST_READ;
               end
            end
         end
         // heads are fetched from the stores
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (!sts.more) begin
               cmd.finish = 1'b1;
               state_in   = ST_EMIT_LAST;
            end else begin
               cmd.compare = 1'b1;
               state_in    = sts.emit ? ST_EMIT : ST_READ;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_READ;
            end
         end
         ST_EMIT_LAST: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/sparse_polynomial_add.sv =====
// Sparse polynomial adder: loads list A then list B (one term per cycle,
// descending exponents), and the item that closes list B starts the merge.
// Each store holds MAX_TERMS terms; extra terms are dropped and flagged as
// overflow on every result of the following merge. While merging the block
// takes no request. Each merge step passes through ST_READ and ST_COMPARE
// (the stores have a registered read port, so the heads arrive in the cycle
// after the pointers move), and each result adds its response transfer. A
// step consumes one term, or two on matching exponents, and out_last marks
// the final result. Coefficients are signed Q16.16, sums saturate, and a
// pair summing to zero is dropped; an empty sum gives one result with
// sum_empty set.
// Depends on spa_pkg, spa_channels, spa_ctrl and spa_datapath.
`timescale 1ns / 1ps

module sparse_polynomial_add
   import spa_pkg::*;
#(
   parameter int MAX_TERMS = 16
) (
   input  logic   clock,
   input  logic   reset,
   spa_req_if.sink   req_port,
   spa_rsp_if.source rsp_port
);

   cmd_type cmd;
   sts_type sts;

   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   spa_datapath #(
      .MAX_TERMS (MAX_TERMS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .list_select     (req_port.list_select),
      .term_valid      (req_port.term_valid),
      .exponent        (req_port.exponent),
      .coefficient     (req_port.coefficient),
      .last_term       (req_port.last_term),
      .out_exponent    (rsp_port.out_exponent),
      .out_coefficient (rsp_port.out_coefficient),
      .out_last        (rsp_port.out_last),
      .sum_empty       (rsp_port.sum_empty),
      .overflow        (rsp_port.overflow)
   );

endmodule

// ===== bench/tb_sparse_polynomial_add.sv =====
// Testbench for sparse_polynomial_add: directed table, then random polynomial pairs,
// checked against an in-bench merge predictor with random idling on both channels.
// Depends on spa_pkg, spa_channels and the sparse_polynomial_add RTL.
`timescale 1ns / 1ps

module tb_sparse_polynomial_add;
   import spa_pkg::*;

   localparam int MAX_TERMS     = 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 200;
   localparam int REPORT_LIMIT  = 10;
   localparam int DIRECTED_ROWS = 25;

   localparam logic LIST_A = 1'b0;
   localparam logic LIST_B = 1'b1;

   typedef struct packed {
      logic              list_select;
      logic              term_valid;
      logic [EXP_W-1:0]  exponent;
      logic [COEF_W-1:0] coefficient;
      logic              last_term;
   } term_req_type;

   typedef struct packed {
      logic [EXP_W-1:0]  exponent;
      logic [COEF_W-1:0] coefficient;
      logic              out_last;
      logic              sum_empty;
      logic              overflow;
   } sum_term_type;

   typedef struct packed {
      term_req_type item;
      logic         typed;
      sum_term_type want;
   } directed_row_type;

   localparam sum_term_type EMPTY_SUM = '{16'h0000, 32'h0000_0000, 1'b1, 1'b1, 1'b0};
   localparam sum_term_type NO_SUM    = '0;

   // typed rows close a pair whose single result is obvious; the rest go to the predictor
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{'{LIST_B, 1'b0, 16'h0000, 32'h0000_0000, 1'b1}, 1'b1, EMPTY_SUM},
      '{'{LIST_B, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_A, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_SUM},
      '{'{LIST_A, 1'b1, 16'hFFFF, 32'h7FFF_FFFF, 1'b1}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'hFFFF, 32'h7FFF_FFFF, 1'b1}, 1'b1,
        '{16'hFFFF, COEF_MAX, 1'b1, 1'b0, 1'b0}},
      '{'{LIST_A, 1'b1, 16'h0000, 32'h8000_0000, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h0000, 32'h8000_0000, 1'b1}, 1'b1,
        '{16'h0000, COEF_MIN, 1'b1, 1'b0, 1'b0}},
      '{'{LIST_A, 1'b1, 16'h0007, 32'h0001_0000, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h0007, 32'hFFFF_0000, 1'b1}, 1'b1, EMPTY_SUM},
      '{'{LIST_A, 1'b1, 16'h0003, 32'h0000_0000, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_A, 1'b0, 16'h0000, 32'h0000_0000, 1'b1}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h0009, 32'h0000_0005, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h0002, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_SUM},
      '{'{LIST_A, 1'b1, 16'h0001, 32'h0000_0001, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_A, 1'b1, 16'h000A, 32'h0000_0002, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h0005, 32'h0000_0003, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h0014, 32'h0000_0004, 1'b1}, 1'b0, NO_SUM},
      '{'{LIST_A, 1'b1, 16'h0028, 32'h0002_0000, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_A, 1'b1, 16'h001E, 32'hFFFE_8000, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h0032, 32'h0001_0000, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h0028, 32'h0000_8000, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h001E, 32'h0001_8000, 1'b0}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b1, 16'h0014, 32'hFFFD_0000, 1'b1}, 1'b0, NO_SUM},
      '{'{LIST_A, 1'b1, 16'h000C, 32'h1234_5678, 1'b1}, 1'b0, NO_SUM},
      '{'{LIST_B, 1'b0, 16'h0000, 32'h0000_0000, 1'b1}, 1'b1,
        '{16'h000C, 32'h1234_5678, 1'b1, 1'b0, 1'b0}}
   };

   logic clock;
   logic reset;

   spa_req_if req_if ();
   spa_rsp_if rsp_if ();

   sparse_polynomial_add #(.MAX_TERMS(MAX_TERMS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   // predictor copy of the two term stores
   logic [EXP_W-1:0]  a_exponents    [MAX_TERMS];
   logic [COEF_W-1:0] a_coefficients [MAX_TERMS];
   logic [EXP_W-1:0]  b_exponents    [MAX_TERMS];
   logic [COEF_W-1:0] b_coefficients [MAX_TERMS];
   int   a_count       = 0;
   int   b_count       = 0;
   logic terms_dropped = 1'b0;

   sum_term_type expected_terms [$];
   int           mismatches   = 0;
   int           quiet_cycles = 0;
   int           random_items = 0;
   bit           calm         = 1'b0;
   logic         row_typed    = 1'b0;
   sum_term_type row_want     = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sum_term_type sum_term(logic [EXP_W-1:0] e, logic [COEF_W-1:0] c);
      return '{e, c, 1'b0, 1'b0, terms_dropped};
   endfunction

   function automatic string describe(sum_term_type s);
      return $sformatf("exp %h coef %h last %b empty %b ovf %b",
                       s.exponent, s.coefficient, s.out_last, s.sum_empty, s.overflow);
   endfunction

   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // store one accepted request; the item closing list B merges both stores
   task automatic take_term(input term_req_type t, input logic typed,
                            input sum_term_type want);
      sum_term_type           sums [$];
      sum_term_type           tail;
      logic signed [COEF_W:0] total;
      int                     ia;
      int                     ib;
      if (t.term_valid) begin
         if (t.list_select == LIST_A) begin
            if (a_count < MAX_TERMS) begin
               a_exponents[a_count]    = t.exponent;
               a_coefficients[a_count] = t.coefficient;
               a_count++;
            end else begin
               terms_dropped = 1'b1;
            end
         end else begin
            if (b_count < MAX_TERMS) begin
               b_exponents[b_count]    = t.exponent;
               b_coefficients[b_count] = t.coefficient;
               b_count++;
            end else begin
               terms_dropped = 1'b1;
            end
         end
      end
      if (t.list_select == LIST_B && t.last_term) begin
         ia = 0;
         ib = 0;
         while (ia < a_count && ib < b_count) begin
            if (a_exponents[ia] == b_exponents[ib]) begin
               total = $signed({a_coefficients[ia][COEF_W-1], a_coefficients[ia]})
                     + $signed({b_coefficients[ib][COEF_W-1], b_coefficients[ib]});
               if (total[COEF_W] != total[COEF_W-1])
                  sums.push_back(sum_term(a_exponents[ia], total[COEF_W] ? COEF_MIN : COEF_MAX));
               else if (total != 0)
                  sums.push_back(sum_term(a_exponents[ia], total[COEF_W-1:0]));
               ia++;
               ib++;
            end else if (a_exponents[ia] < b_exponents[ib]) begin
               sums.push_back(sum_term(b_exponents[ib], b_coefficients[ib]));
               ib++;
            end else begin
               sums.push_back(sum_term(a_exponents[ia], a_coefficients[ia]));
               ia++;
            end
         end
         for (; ia < a_count; ia++) sums.push_back(sum_term(a_exponents[ia], a_coefficients[ia]));
         for (; ib < b_count; ib++) sums.push_back(sum_term(b_exponents[ib], b_coefficients[ib]));
         if (sums.size() == 0) begin
            sums.push_back('{'0, '0, 1'b1, 1'b1, terms_dropped});
         end else begin
            tail = sums.pop_back();
            tail.out_last = 1'b1;
            sums.push_back(tail);
         end
         if (typed) expected_terms.push_back(want);
         else foreach (sums[i]) expected_terms.push_back(sums[i]);
         a_count       = 0;
         b_count       = 0;
         terms_dropped = 1'b0;
      end
   endtask

   task automatic check_sum_term(input sum_term_type got);
      sum_term_type want;
      string        bad;
      if (expected_terms.size() == 0) begin
         log_mismatch($sformatf("unexpected result: %s", describe(got)));
         return;
      end
      want = expected_terms.pop_front();
      bad  = "";
      if (got.exponent    !== want.exponent)    bad = {bad, " out_exponent"};
      if (got.coefficient !== want.coefficient) bad = {bad, " out_coefficient"};
      if (got.out_last    !== want.out_last)    bad = {bad, " out_last"};
      if (got.sum_empty   !== want.sum_empty)   bad = {bad, " sum_empty"};
      if (got.overflow    !== want.overflow)    bad = {bad, " overflow"};
      if (bad != "")
         log_mismatch($sformatf("mismatch in%s: expected %s, got %s",
                                bad, describe(want), describe(got)));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            take_term('{req_if.list_select, req_if.term_valid, req_if.exponent,
                        req_if.coefficient, req_if.last_term}, row_typed, row_want);
         if (rsp_if.valid && rsp_if.ready)
            check_sum_term('{rsp_if.out_exponent, rsp_if.out_coefficient, rsp_if.out_last,
                             rsp_if.sum_empty, rsp_if.overflow});
      end
   end

   // watchdog: too long without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) rsp_if.ready <= calm || ($urandom_range(99) >= 13);

   task automatic send_item(input term_req_type t, input logic typed,
                            input sum_term_type want);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 13) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.list_select <= t.list_select;
      req_if.term_valid  <= t.term_valid;
      req_if.exponent    <= t.exponent;
      req_if.coefficient <= t.coefficient;
      req_if.last_term   <= t.last_term;
      row_typed = typed;
      row_want  = want;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_terms.size() != 0) @(negedge clock);
   endtask

   task automatic scramble(ref term_req_type q [$]);
      term_req_type tmp;
      int           j;
      for (int i = q.size() - 1; i > 0; i--) begin
         j    = $urandom_range(i);
         tmp  = q[i];
         q[i] = q[j];
         q[j] = tmp;
      end
   endtask

   // one pair of polynomials: mostly descending lists with shared exponents,
   // sometimes oversized, scrambled, interleaved or salted with ignored markers
   task automatic send_random_pair(input bit force_overflow);
      term_req_type      a_terms [$];
      term_req_type      b_terms [$];
      term_req_type      order [$];
      term_req_type      t;
      term_req_type      closer;
      logic [COEF_W-1:0] c;
      int                k;
      int                e;
      int                roll;
      bit                in_a;
      bit                in_b;
      bit                oversized;
      bit                broken;
      oversized = force_overflow || ($urandom_range(99) < 8);
      broken    = ($urandom_range(99) < 15);
      k = oversized ? $urandom_range(18, 26) : $urandom_range(0, 12);
      e = (oversized || $urandom_range(9) == 0) ? 65535 : $urandom_range(65535);
      for (int i = 0; i < k && e >= 0; i++) begin
         roll = $urandom_range(99);
         in_a = oversized ? (roll < 85) : (roll < 65);
         in_b = oversized ? (roll >= 15) : (roll >= 35);
         c = ($urandom_range(99) < 8) ? ($urandom_range(1) ? COEF_MAX : COEF_MIN) : $urandom;
         t = '{LIST_A, 1'b1, e[EXP_W-1:0], c, 1'b0};
         if (in_a) a_terms.push_back(t);
         if (in_b) begin
            t.list_select = LIST_B;
            roll = $urandom_range(9);
            if (!in_a || roll > 3) t.coefficient = $urandom;
            else if (roll < 3) t.coefficient = -c;   // cancels to zero unless c is COEF_MIN
            if (!in_a && $urandom_range(99) < 8) t.coefficient = COEF_MIN;
            b_terms.push_back(t);
         end
         e -= oversized ? $urandom_range(1, 64) : $urandom_range(1, 6000);
      end
      if (broken) begin
         scramble(a_terms);
         scramble(b_terms);
         foreach (a_terms[i]) a_terms[i].last_term = 1'($urandom_range(1));
      end else if (a_terms.size() != 0 && $urandom_range(9) < 8) begin
         t = a_terms.pop_back();
         t.last_term = 1'b1;
         a_terms.push_back(t);
      end
      if (b_terms.size() != 0 && $urandom_range(9) != 0) begin
         closer = b_terms.pop_back();
      end else begin
         closer.list_select = LIST_B;
         closer.term_valid  = 1'b0;
         closer.exponent    = EXP_W'($urandom);
         closer.coefficient = $urandom;
      end
      closer.last_term = 1'b1;
      if (broken && $urandom_range(1)) begin
         while (a_terms.size() + b_terms.size() != 0) begin
            if (b_terms.size() == 0 || (a_terms.size() != 0 && $urandom_range(1)))
               order.push_back(a_terms.pop_front());
            else
               order.push_back(b_terms.pop_front());
         end
      end else begin
         order = {a_terms, b_terms};
      end
      if ($urandom_range(9) == 0) begin
         t.list_select = 1'($urandom_range(1));
         t.term_valid  = 1'b0;
         t.exponent    = EXP_W'($urandom);
         t.coefficient = $urandom;
         t.last_term   = (t.list_select == LIST_B) ? 1'b0 : 1'($urandom_range(1));
         order.insert($urandom_range(order.size()), t);
      end
      order.push_back(closer);
      foreach (order[i]) begin
         send_item(order[i], 1'b0, NO_SUM);
         if (order[i].term_valid || (order[i].list_select == LIST_B && order[i].last_term))
            random_items++;
      end
   endtask

   initial begin
      bit first_pair;
      clock              = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.list_select = 1'b0;
      req_if.term_valid  = 1'b0;
      req_if.exponent    = '0;
      req_if.coefficient = '0;
      req_if.last_term   = 1'b0;
      rsp_if.ready       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
      hold_until_drained();

      first_pair = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         calm = (random_items >= 90 && random_items < 150);
         if ($urandom_range(4) == 0) hold_until_drained();
         send_random_pair(first_pair);
         first_pair = 1'b0;
      end
      calm = 1'b0;
      @(negedge clock);
      req_if.valid <= 1'b0;

      while (expected_terms.size() != 0) @(posedge clock);
      repeat (8 * MAX_TERMS) @(posedge clock);

      if (mismatches == 0 && expected_terms.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sparse_polynomial_add.f =====
+incdir+design
design/spa_pkg.sv
design/spa_channels.sv
design/spa_datapath.sv
design/spa_ctrl.sv
design/sparse_polynomial_add.sv
bench/tb_sparse_polynomial_add.sv
